/* src/tws_pkg.sv */
`default_nettype none

package tws_pkg;

  // Window length of the running average.
  localparam int unsigned WINDOW_LEN = 100;

  // Field and register widths.
  localparam int unsigned ADC_W  = 10;
  localparam int unsigned TEMP_W = 17;
  localparam int unsigned SUM_W  = 24;
  localparam int unsigned SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int unsigned CNT_W  = $clog2(WINDOW_LEN + 1);
  localparam int unsigned DCNT_W = $clog2(SUM_W);

  // One converter step is 1/2.048 degree, which is 125/256 degree.
  localparam logic [TEMP_W-1:0] TEMP_SCALE = TEMP_W'(125);
  // Minimum tracker starts at 200 degrees in 1/256 degree units.
  localparam logic [TEMP_W-1:0] LOW_RESET  = TEMP_W'(51200);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_ADD,
    ST_DIV,
    ST_OUT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the new temperature, read the oldest ring entry
    logic update;    // min/max, ring write, count, slot, subtract the oldest
    logic accum;     // add the new temperature, arm the divider
    logic div_step;  // one restoring division step
  } cmd_t;

endpackage

`default_nettype wire

/* src/tws_if.sv */
`default_nettype none

interface tws_in_if
  import tws_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              take_sample;
  logic [ADC_W-1:0]  adc_value;

  modport source (output valid, output take_sample, output adc_value, input ready);
  modport sink   (input valid, input take_sample, input adc_value, output ready);
endinterface

interface tws_out_if
  import tws_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [TEMP_W-1:0] current_temp;
  logic [TEMP_W-1:0] minimum_temp;
  logic [TEMP_W-1:0] maximum_temp;
  logic [TEMP_W-1:0] average_temp;

  modport source (output valid, output current_temp, output minimum_temp,
                  output maximum_temp, output average_temp, input ready);
  modport sink   (input valid, input current_temp, input minimum_temp,
                  input maximum_temp, input average_temp, output ready);
endinterface

`default_nettype wire

/* src/tws_ctrl.sv */
`default_nettype none

module tws_ctrl
  import tws_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  input  wire  take_i,
  input  wire  out_ready_i,
  output logic in_ready_o,
  output logic out_valid_o,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic [DCNT_W-1:0] div_cnt_q, div_cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      div_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      div_cnt_q <= div_cnt_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    div_cnt_d   = div_cnt_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        // A request without the take flag is consumed and dropped.
        if (in_valid_i && take_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_ADD;
      end
      ST_ADD: begin
        cmd_o.accum = 1'b1;
        div_cnt_d   = '0;
        state_d     = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        div_cnt_d      = div_cnt_q + DCNT_W'(1);
        if (div_cnt_q == DCNT_W'(SUM_W - 1)) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/tws_dp.sv */
`default_nettype none

module tws_dp
  import tws_pkg::*;
(
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire  cmd_t         cmd_i,
  input  wire  [ADC_W-1:0]   adc_value_i,
  output logic [TEMP_W-1:0]  current_temp_o,
  output logic [TEMP_W-1:0]  minimum_temp_o,
  output logic [TEMP_W-1:0]  maximum_temp_o,
  output logic [TEMP_W-1:0]  average_temp_o
);

  logic [TEMP_W-1:0] ring_q [WINDOW_LEN];

  logic [SLOT_W-1:0] slot_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [SUM_W-1:0]  sum_q;
  logic [TEMP_W-1:0] low_q;
  logic [TEMP_W-1:0] high_q;

  logic [TEMP_W-1:0] temp_q;
  logic [TEMP_W-1:0] old_q;
  logic [SUM_W-1:0]  dq_q;
  logic [CNT_W-1:0]  rem_q;

  logic              full;
  logic [TEMP_W-1:0] temp_d;
  logic [SUM_W-1:0]  sum_add;
  logic [CNT_W:0]    trial;
  logic              fits;
  logic [CNT_W:0]    trial_sub;

  assign full    = (cnt_q == CNT_W'(WINDOW_LEN));
  assign temp_d  = TEMP_W'({{(TEMP_W-ADC_W){1'b0}}, adc_value_i} * TEMP_SCALE);
  assign sum_add = sum_q + {{(SUM_W-TEMP_W){1'b0}}, temp_q};

  // Restoring division: shift the next dividend bit into the remainder.
  assign trial     = {rem_q, dq_q[SUM_W-1]};
  assign fits      = (trial >= {1'b0, cnt_q});
  assign trial_sub = trial - {1'b0, cnt_q};

  // Ring memory: read the slot about to be overwritten, write it in the following cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      old_q <= ring_q[slot_q];
    end
    if (cmd_i.update) begin
      ring_q[slot_q] <= temp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      temp_q <= temp_d;
    end
    if (cmd_i.accum) begin
      dq_q  <= sum_add;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      dq_q  <= {dq_q[SUM_W-2:0], fits};
      rem_q <= fits ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      cnt_q  <= '0;
      sum_q  <= '0;
      low_q  <= LOW_RESET;
      high_q <= '0;
    end else begin
      if (cmd_i.update) begin
        if (temp_q < low_q) begin
          low_q <= temp_q;
        end
        if (temp_q > high_q) begin
          high_q <= temp_q;
        end
        if (full) begin
          sum_q <= sum_q - {{(SUM_W-TEMP_W){1'b0}}, old_q};
        end else begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
        if (slot_q == SLOT_W'(WINDOW_LEN - 1)) begin
          slot_q <= '0;
        end else begin
          slot_q <= slot_q + SLOT_W'(1);
        end
      end
      if (cmd_i.accum) begin
        sum_q <= sum_add;
      end
    end
  end

  assign current_temp_o = temp_q;
  assign minimum_temp_o = low_q;
  assign maximum_temp_o = high_q;
  assign average_temp_o = dq_q[TEMP_W-1:0];

endmodule

`default_nettype wire

/* src/temperature_window_statistics_unit.sv */
// Channel   Modport            Direction  Payload
// in_req_i  tws_in_if.sink     in         take_sample, adc_value
// res_o     tws_out_if.source  out        current_temp, minimum_temp, maximum_temp, average_temp
//
// A request with take_sample set yields one result after capture and ring read,
// the window update, the sum accumulation, and the bit-serial division of the
// 24-bit window sum by the sample count.
// A request with take_sample clear is accepted and yields no result.
// One request is worked on at a time; in_req_i.ready is high only while idle.
// A result holds on res_o until it is taken; stalls there hold off new requests.
// Reset is asynchronous and active low; the sample ring needs no clearing pass.
`default_nettype none

module temperature_window_statistics_unit
  import tws_pkg::*;
(
  input  wire              clk_i,
  input  wire              rst_ni,
  tws_in_if.sink           in_req_i,
  tws_out_if.source        res_o
);

  // The controller sequences each request through capture, window update,
  // sum accumulation, division and result hand-off. The datapath holds the
  // ring memory, the running sum, the min/max trackers and the divider.
  cmd_t cmd;

  tws_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_req_i.valid),
    .take_i      (in_req_i.take_sample),
    .out_ready_i (res_o.ready),
    .in_ready_o  (in_req_i.ready),
    .out_valid_o (res_o.valid),
    .cmd_o       (cmd)
  );

  tws_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .adc_value_i    (in_req_i.adc_value),
    .current_temp_o (res_o.current_temp),
    .minimum_temp_o (res_o.minimum_temp),
    .maximum_temp_o (res_o.maximum_temp),
    .average_temp_o (res_o.average_temp)
  );

  // The block never offers a result and takes a request in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> !in_req_i.ready)
    else $error("request taken while a result is pending");

  // The current sample lies between the tracked extremes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.minimum_temp <= res_o.current_temp) &&
                    (res_o.current_temp <= res_o.maximum_temp))
    else $error("current temperature outside min/max");

  // The window mean cannot leave the range of all samples seen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.minimum_temp <= res_o.average_temp) &&
                    (res_o.average_temp <= res_o.maximum_temp))
    else $error("average outside min/max");

  // A request without the take flag starts no work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_req_i.valid && in_req_i.ready && !in_req_i.take_sample) |=> in_req_i.ready)
    else $error("ignored request started processing");

endmodule

`default_nettype wire
